[hw/rtl/clst_pkg.sv]
// Shared constants and types for the circular list engine.
`timescale 1ns / 1ps

package clst_pkg;

  localparam int unsigned POOL_DEPTH_DEF = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned CMD_BITS       = 4;
  localparam int unsigned STATUS_BITS    = 2;

  localparam logic [CMD_BITS-1:0] CMD_INS_FRONT = 4'd0;
  localparam logic [CMD_BITS-1:0] CMD_INS_AFTER = 4'd1;
  localparam logic [CMD_BITS-1:0] CMD_INS_BACK  = 4'd2;
  localparam logic [CMD_BITS-1:0] CMD_DEL_FRONT = 4'd3;
  localparam logic [CMD_BITS-1:0] CMD_DEL_VALUE = 4'd4;
  localparam logic [CMD_BITS-1:0] CMD_DEL_BACK  = 4'd5;
  localparam logic [CMD_BITS-1:0] CMD_SEARCH    = 4'd6;
  localparam logic [CMD_BITS-1:0] CMD_COUNT     = 4'd7;
  localparam logic [CMD_BITS-1:0] CMD_SUM       = 4'd8;

  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_WALK,
    S_INS_CHK,
    S_INS_NODE,
    S_INS_LINK,
    S_DEL,
    S_DONE
  } seq_state_e;

  typedef enum logic [1:0] {
    DK_FRONT_SINGLE,
    DK_FRONT_MULTI,
    DK_UNLINK
  } del_kind_e;

endpackage

[hw/rtl/clst_node_store.sv]
// Node pool memories: value and link, one write port each, shared registered read.
`timescale 1ns / 1ps

module clst_node_store import clst_pkg::*; #(
  parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  localparam int unsigned IdxBits = $clog2(POOL_DEPTH)
) (
  input  logic                  clk_i,
  input  logic [IdxBits-1:0]    rd_addr_i,
  output logic [VALUE_BITS-1:0] rd_value_o,
  output logic [IdxBits-1:0]    rd_link_o,
  input  logic                  val_we_i,
  input  logic [IdxBits-1:0]    val_waddr_i,
  input  logic [VALUE_BITS-1:0] val_wdata_i,
  input  logic                  link_we_i,
  input  logic [IdxBits-1:0]    link_waddr_i,
  input  logic [IdxBits-1:0]    link_wdata_i
);

  logic [VALUE_BITS-1:0] value_mem [POOL_DEPTH];
  logic [IdxBits-1:0]    link_mem  [POOL_DEPTH];

  always_ff @(posedge clk_i) begin
    if (val_we_i) begin
      value_mem[val_waddr_i] <= val_wdata_i;
    end
    rd_value_o <= value_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (link_we_i) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    rd_link_o <= link_mem[rd_addr_i];
  end

endmodule

[hw/rtl/clst_free_stack.sv]
// Free node stack in memory, with a low-water mark standing in for the reset fill.
`timescale 1ns / 1ps

module clst_free_stack import clst_pkg::*; #(
  parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF,
  localparam int unsigned IdxBits = $clog2(POOL_DEPTH),
  localparam int unsigned CntBits = $clog2(POOL_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_i,
  input  logic               push_i,
  input  logic [IdxBits-1:0] push_node_i,
  output logic               empty_o,
  output logic [IdxBits-1:0] top_node_o
);

  logic [IdxBits-1:0] stack_mem [POOL_DEPTH];
  logic [CntBits-1:0] top_q, top_d;
  logic [CntBits-1:0] mark_q, mark_d;
  logic [CntBits-1:0] rd_ptr;
  logic [IdxBits-1:0] rd_data_q, rd_addr_q;
  logic               rd_fresh_q;

  // Entries below the mark were never written; their own index is read in their place.
  assign rd_ptr     = top_q - CntBits'(1);
  assign empty_o    = (top_q == '0);
  assign top_node_o = rd_fresh_q ? rd_addr_q : rd_data_q;

  always_comb begin
    top_d  = top_q;
    mark_d = mark_q;
    if (pop_i && !empty_o) begin
      top_d = rd_ptr;
      if (rd_ptr < mark_q) begin
        mark_d = rd_ptr;
      end
    end else if (push_i && (top_q < CntBits'(POOL_DEPTH))) begin
      top_d = top_q + CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= CntBits'(POOL_DEPTH);
      mark_q <= CntBits'(POOL_DEPTH);
    end else begin
      top_q  <= top_d;
      mark_q <= mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && (top_q < CntBits'(POOL_DEPTH))) begin
      stack_mem[top_q[IdxBits-1:0]] <= push_node_i;
    end
    rd_data_q  <= stack_mem[rd_ptr[IdxBits-1:0]];
    rd_addr_q  <= rd_ptr[IdxBits-1:0];
    rd_fresh_q <= (rd_ptr < mark_q);
  end

endmodule

[hw/rtl/circular_list_engine_unit.sv]
// Circular list engine: command sequencer over the node pool and free stack.
// Sequence: count goes from dispatch to done; inserts at front or back take the node step and,
//   unless the list was empty, the link step; short deletes take the delete step; walks visit
//   one node per cycle, up to the count, and insert after key takes check, node and link steps.
// Throughput: one command at a time; the next is taken once the result is posted and the
//   engine is back in idle; the list walk reads one node per cycle.
// Reset: asynchronous active low; list empty, free stack full via a low-water mark,
//   no clearing pass, so the first command is taken right after reset.
`timescale 1ns / 1ps

module circular_list_engine_unit import clst_pkg::*; #(
  parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  localparam int unsigned IdxBits = $clog2(POOL_DEPTH),
  localparam int unsigned CntBits = $clog2(POOL_DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [CMD_BITS-1:0]          cmd_i,
  input  logic signed [VALUE_BITS-1:0] item_value_i,
  input  logic signed [VALUE_BITS-1:0] anchor_key_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [STATUS_BITS-1:0]       status_o,
  output logic                         found_o,
  output logic [CntBits-1:0]           element_total_o,
  output logic signed [VALUE_BITS-1:0] value_sum_o
);

  seq_state_e state_q, state_d;
  del_kind_e  kind_q, kind_d;

  // Command word held for the whole sequence.
  logic [CMD_BITS-1:0]   cmd_q, cmd_d;
  logic [VALUE_BITS-1:0] val_q, val_d, key_q, key_d;

  // List descriptor.
  logic [IdxBits-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntBits-1:0] count_q, count_d;

  // Walk and edit scratch.
  logic [IdxBits-1:0]    p_q, p_d, prev_q, prev_d, hlink_q, hlink_d, plink_q, plink_d;
  logic [IdxBits-1:0]    nx_q, nx_d, rel_q, rel_d, lw_q, lw_d, n_q, n_d;
  logic [CntBits-1:0]    i_q, i_d;
  logic [VALUE_BITS-1:0] sum_q, sum_d;
  logic [STATUS_BITS-1:0] status_q, status_d;
  logic                  found_q, found_d;

  // Output word register.
  logic                   out_valid_q, out_valid_d;
  logic [STATUS_BITS-1:0] out_status_q, out_status_d;
  logic                   out_found_q, out_found_d;
  logic [CntBits-1:0]     out_total_q, out_total_d;
  logic [VALUE_BITS-1:0]  out_sum_q, out_sum_d;

  // Memory ports.
  logic [IdxBits-1:0]    rd_addr;
  logic [VALUE_BITS-1:0] rval;
  logic [IdxBits-1:0]    rlink;
  logic                  val_we, link_we;
  logic [IdxBits-1:0]    val_waddr, link_waddr, link_wdata;
  logic                  fs_pop, fs_push, fs_empty;
  logic [IdxBits-1:0]    fs_top;

  logic in_accept, last, match_key, match_val, back_stop;

  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign last       = ((i_q + CntBits'(1)) == count_q);
  assign match_key  = (rval == key_q);
  assign match_val  = (rval == val_q);
  // Delete-back stops at the node two before the tail, whose link names the node before the tail.
  assign back_stop  = (({1'b0, i_q} + (CntBits + 1)'(3)) == {1'b0, count_q});

  clst_node_store #(
    .POOL_DEPTH(POOL_DEPTH),
    .VALUE_BITS(VALUE_BITS)
  ) u_nodes (
    .clk_i       (clk_i),
    .rd_addr_i   (rd_addr),
    .rd_value_o  (rval),
    .rd_link_o   (rlink),
    .val_we_i    (val_we),
    .val_waddr_i (val_waddr),
    .val_wdata_i (val_q),
    .link_we_i   (link_we),
    .link_waddr_i(link_waddr),
    .link_wdata_i(link_wdata)
  );

  clst_free_stack #(
    .POOL_DEPTH(POOL_DEPTH)
  ) u_free (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_i      (fs_pop),
    .push_i     (fs_push),
    .push_node_i(rel_q),
    .empty_o    (fs_empty),
    .top_node_o (fs_top)
  );

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cmd_d   = cmd_q;
    val_d   = val_q;
    key_d   = key_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    p_d     = p_q;
    prev_d  = prev_q;
    hlink_d = hlink_q;
    plink_d = plink_q;
    nx_d    = nx_q;
    rel_d   = rel_q;
    lw_d    = lw_q;
    n_d     = n_q;
    i_d     = i_q;
    sum_d   = sum_q;
    status_d = status_q;
    found_d  = found_q;

    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_total_d  = out_total_q;
    out_sum_d    = out_sum_q;

    rd_addr    = p_q;
    val_we     = 1'b0;
    val_waddr  = fs_top;
    link_we    = 1'b0;
    link_waddr = lw_q;
    link_wdata = nx_q;
    fs_pop     = 1'b0;
    fs_push    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cmd_d    = cmd_i;
          val_d    = item_value_i;
          key_d    = anchor_key_i;
          status_d = ST_OK;
          found_d  = 1'b0;
          sum_d    = '0;
          state_d  = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        // Launch a walk from the head, or go straight to the insert, delete or done step.
        rd_addr = head_q;
        p_d     = head_q;
        prev_d  = tail_q;
        i_d     = '0;
        state_d = S_DONE;
        case (cmd_q)
          CMD_INS_FRONT, CMD_INS_BACK: begin
            if (fs_empty) begin
              status_d = ST_FULL;
            end else begin
              state_d = S_INS_NODE;
            end
          end
          CMD_COUNT: begin
            if (count_q == '0) status_d = ST_EMPTY;
          end
          CMD_DEL_FRONT: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else if (count_q == CntBits'(1)) begin
              rel_d   = head_q;
              kind_d  = DK_FRONT_SINGLE;
              state_d = S_DEL;
            end else begin
              state_d = S_WALK;
            end
          end
          CMD_DEL_BACK: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else if (count_q == CntBits'(1)) begin
              rel_d   = head_q;
              kind_d  = DK_FRONT_SINGLE;
              state_d = S_DEL;
            end else if (count_q == CntBits'(2)) begin
              kind_d  = DK_UNLINK;
              lw_d    = head_q;
              nx_d    = head_q;
              rel_d   = tail_q;
              state_d = S_DEL;
            end else begin
              state_d = S_WALK;
            end
          end
          CMD_INS_AFTER, CMD_DEL_VALUE, CMD_SEARCH, CMD_SUM: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              state_d = S_WALK;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_WALK: begin
        // rval and rlink belong to node p_q; advance means read its successor.
        if (i_q == '0) hlink_d = rlink;
        state_d = S_WALK;
        case (cmd_q)
          CMD_INS_AFTER: begin
            if (match_key) begin
              plink_d = rlink;
              state_d = S_INS_CHK;
            end else if (last) begin
              p_d     = head_q;
              plink_d = (i_q == '0) ? rlink : hlink_q;
              state_d = S_INS_CHK;
            end
          end
          CMD_DEL_FRONT: begin
            nx_d    = rlink;
            rel_d   = p_q;
            kind_d  = DK_FRONT_MULTI;
            state_d = S_DEL;
          end
          CMD_DEL_VALUE: begin
            if (match_val) begin
              found_d = 1'b1;
              rel_d   = p_q;
              nx_d    = rlink;
              lw_d    = prev_q;
              if (i_q != '0) begin
                kind_d = DK_UNLINK;
              end else if (count_q <= CntBits'(1)) begin
                kind_d = DK_FRONT_SINGLE;
              end else begin
                kind_d = DK_FRONT_MULTI;
              end
              state_d = S_DEL;
            end else if (last) begin
              status_d = ST_NOT_FOUND;
              state_d  = S_DONE;
            end
          end
          CMD_DEL_BACK: begin
            if (back_stop) begin
              kind_d  = DK_UNLINK;
              lw_d    = rlink;
              nx_d    = head_q;
              rel_d   = tail_q;
              state_d = S_DEL;
            end
          end
          CMD_SEARCH: begin
            if (match_val) begin
              found_d = 1'b1;
              state_d = S_DONE;
            end else if (last) begin
              status_d = ST_NOT_FOUND;
              state_d  = S_DONE;
            end
          end
          CMD_SUM: begin
            sum_d = sum_q + rval;
            if (last) state_d = S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
        if (state_d == S_WALK) begin
          p_d     = rlink;
          prev_d  = p_q;
          i_d     = i_q + CntBits'(1);
          rd_addr = rlink;
        end
      end

      S_INS_CHK: begin
        if (fs_empty) begin
          status_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          state_d = S_INS_NODE;
        end
      end

      S_INS_NODE: begin
        // Pop a node and fill it; the first node links to itself.
        n_d       = fs_top;
        fs_pop    = 1'b1;
        val_we    = 1'b1;
        val_waddr = fs_top;
        link_we   = 1'b1;
        link_waddr = fs_top;
        if (cmd_q == CMD_INS_AFTER) begin
          link_wdata = plink_q;
          state_d    = S_INS_LINK;
        end else if (count_q == '0) begin
          link_wdata = fs_top;
          head_d     = fs_top;
          tail_d     = fs_top;
          count_d    = CntBits'(1);
          state_d    = S_DONE;
        end else begin
          link_wdata = head_q;
          state_d    = S_INS_LINK;
        end
      end

      S_INS_LINK: begin
        link_we    = 1'b1;
        link_wdata = n_q;
        link_waddr = (cmd_q == CMD_INS_AFTER) ? p_q : tail_q;
        count_d    = count_q + CntBits'(1);
        if (cmd_q == CMD_INS_FRONT) begin
          head_d = n_q;
        end else if (cmd_q == CMD_INS_BACK) begin
          tail_d = n_q;
        end else if (p_q == tail_q) begin
          tail_d = n_q;
        end
        state_d = S_DONE;
      end

      S_DEL: begin
        // Patch one link unless the list empties, update the descriptor and return the node.
        fs_push = 1'b1;
        unique case (kind_q)
          DK_FRONT_SINGLE: begin
            head_d  = '0;
            tail_d  = '0;
            count_d = '0;
          end
          DK_FRONT_MULTI: begin
            link_we    = 1'b1;
            link_waddr = tail_q;
            head_d     = nx_q;
            count_d    = count_q - CntBits'(1);
          end
          DK_UNLINK: begin
            link_we = 1'b1;
            if (rel_q == tail_q) tail_d = lw_q;
            count_d = count_q - CntBits'(1);
          end
          default: begin
            fs_push = 1'b0;
          end
        endcase
        state_d = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_found_d  = found_q;
          out_total_d  = count_q;
          out_sum_d    = sum_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    cmd_q        <= cmd_d;
    val_q        <= val_d;
    key_q        <= key_d;
    p_q          <= p_d;
    prev_q       <= prev_d;
    hlink_q      <= hlink_d;
    plink_q      <= plink_d;
    nx_q         <= nx_d;
    rel_q        <= rel_d;
    lw_q         <= lw_d;
    n_q          <= n_d;
    i_q          <= i_d;
    sum_q        <= sum_d;
    status_q     <= status_d;
    found_q      <= found_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_total_q  <= out_total_d;
    out_sum_q    <= out_sum_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign found_o         = out_found_q;
  assign element_total_o = out_total_q;
  assign value_sum_o     = out_sum_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(POOL_DEPTH))
    else $error("node count exceeds pool depth");

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_DISPATCH))
    else $error("accepted command did not dispatch");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_NODE) |-> !fs_empty)
    else $error("insert with an empty free stack");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result raised outside the done step");
`endif

endmodule

[tb/circular_list_engine_unit_tb.sv]
// Self-checking testbench for the circular list engine: directed and random commands.
`timescale 1ns / 1ps

module circular_list_engine_unit_tb;
  import clst_pkg::*;

  localparam int unsigned DEPTH = POOL_DEPTH_DEF;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic                   found;
    logic [6:0]             total;
    logic [31:0]            sum;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [CMD_BITS-1:0] cmd_i = CMD_COUNT;
  logic signed [31:0] item_value_i = '0;
  logic signed [31:0] anchor_key_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [STATUS_BITS-1:0] status_o;
  logic found_o;
  logic [6:0] element_total_o;
  logic signed [31:0] value_sum_o;

  circular_list_engine_unit dut (.*);

  // Clock: 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mirror of the list contents, head first. Node indexes never show at the
  // ports, so an ordered queue of values is enough to predict every answer.
  logic [31:0] list_vals[$];
  answer_t pending_answers[$];
  bit failed = 1'b0;
  bit quiet = 1'b0;  // suppresses input idling and output stalls for a stretch
  int sent = 0;

  function automatic answer_t predict_answer(logic [CMD_BITS-1:0] cmd, logic [31:0] val,
                                             logic [31:0] key);
    answer_t a;
    int pos;
    a = '0;
    pos = -1;
    case (cmd)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        if (list_vals.size() >= DEPTH) a.status = ST_FULL;
        else if (cmd == CMD_INS_FRONT) list_vals.push_front(val);
        else list_vals.push_back(val);
      end
      CMD_INS_AFTER: begin
        if (list_vals.size() == 0) a.status = ST_EMPTY;
        else if (list_vals.size() >= DEPTH) a.status = ST_FULL;
        else begin
          pos = 0;  // missing key: place after head
          foreach (list_vals[i]) if (list_vals[i] == key) begin
            pos = i;
            break;
          end
          list_vals.insert(pos + 1, val);
        end
      end
      CMD_DEL_FRONT: begin
        if (list_vals.size() == 0) a.status = ST_EMPTY;
        else void'(list_vals.pop_front());
      end
      CMD_DEL_BACK: begin
        if (list_vals.size() == 0) a.status = ST_EMPTY;
        else void'(list_vals.pop_back());
      end
      CMD_DEL_VALUE, CMD_SEARCH: begin
        if (list_vals.size() == 0) a.status = ST_EMPTY;
        else begin
          foreach (list_vals[i]) if (list_vals[i] == val) begin
            pos = i;
            break;
          end
          if (pos < 0) a.status = ST_NOT_FOUND;
          else begin
            a.found = 1'b1;
            if (cmd == CMD_DEL_VALUE) list_vals.delete(pos);
          end
        end
      end
      CMD_COUNT: if (list_vals.size() == 0) a.status = ST_EMPTY;
      CMD_SUM: begin
        if (list_vals.size() == 0) a.status = ST_EMPTY;
        else foreach (list_vals[i]) a.sum += list_vals[i];
      end
      default: ;
    endcase
    a.total = 7'(list_vals.size());
    return a;
  endfunction

  // Send one command word; hold it until accepted, then predict its answer.
  task automatic send_cmd(logic [CMD_BITS-1:0] cmd, logic [31:0] val, logic [31:0] key);
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    cmd_i <= cmd;
    item_value_i <= val;
    anchor_key_i <= key;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_answers.push_back(predict_answer(cmd, val, key));
    sent++;
  endtask

  // Receiver: stall at random, check each accepted word against the oldest prediction.
  always @(posedge clk_i) begin
    answer_t exp_a;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_answers.size() == 0) begin
          $display("%t unexpected answer status=%0d total=%0d", $realtime, status_o,
                   element_total_o);
          failed = 1'b1;
        end else begin
          exp_a = pending_answers.pop_front();
          if (status_o !== exp_a.status) begin
            $display("%t status exp %0d got %0d", $realtime, exp_a.status, status_o);
            failed = 1'b1;
          end
          if (found_o !== exp_a.found) begin
            $display("%t found exp %0d got %0d", $realtime, exp_a.found, found_o);
            failed = 1'b1;
          end
          if (element_total_o !== exp_a.total) begin
            $display("%t total exp %0d got %0d", $realtime, exp_a.total, element_total_o);
            failed = 1'b1;
          end
          if (value_sum_o !== exp_a.sum) begin
            $display("%t sum exp %h got %h", $realtime, exp_a.sum, value_sum_o);
            failed = 1'b1;
          end
        end
      end
      out_stall_i <= !quiet && ($urandom_range(99) < 11);
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(7);  // small set so keys and values collide
    endcase
  endfunction

  task automatic test_empty_list();
    for (int c = 0; c <= 15; c++) send_cmd(c[3:0], 32'd5, 32'd5);
  endtask

  task automatic test_edges();
    send_cmd(CMD_INS_BACK, 32'h8000_0000, '0);
    send_cmd(CMD_INS_FRONT, 32'h7FFF_FFFF, '0);
    send_cmd(CMD_INS_AFTER, 32'hFFFF_FFFF, 32'h8000_0000);
    send_cmd(CMD_INS_AFTER, 32'd1, 32'h1234_5678);  // missing key: after head
    send_cmd(CMD_SUM, '0, '0);
    send_cmd(CMD_SEARCH, 32'hFFFF_FFFF, '0);
    send_cmd(CMD_DEL_VALUE, 32'd99, '0);
    send_cmd(CMD_DEL_VALUE, 32'h7FFF_FFFF, '0);  // match at head
    send_cmd(CMD_DEL_VALUE, 32'h8000_0000, '0);  // match in the middle
    send_cmd(CMD_DEL_BACK, '0, '0);
    send_cmd(CMD_DEL_BACK, '0, '0);
    send_cmd(CMD_COUNT, '0, '0);
  endtask

  // Fill the pool, hit the full case on every insert kind, then drain it.
  task automatic test_pool_full();
    for (int i = 0; i < DEPTH; i++) send_cmd(CMD_INS_BACK, $urandom, '0);
    send_cmd(CMD_INS_FRONT, 32'd1, '0);
    send_cmd(CMD_INS_BACK, 32'd1, '0);
    send_cmd(CMD_INS_AFTER, 32'd1, 32'd1);
    send_cmd(CMD_SUM, '0, '0);
    for (int i = 0; i < DEPTH; i++) send_cmd(($urandom_range(1)) ? CMD_DEL_FRONT
                                             : CMD_DEL_BACK, '0, '0);
  endtask

  task automatic test_random(int n);
    logic [CMD_BITS-1:0] cmd;
    for (int i = 0; i < n; i++) begin
      quiet = (i >= n / 3 && i < n / 2);
      if ($urandom_range(19) == 0) cmd = CMD_BITS'($urandom_range(15));
      else if (list_vals.size() < 8) cmd = CMD_BITS'($urandom_range(2));
      else cmd = CMD_BITS'($urandom_range(8));
      send_cmd(cmd, ($urandom_range(3) == 0) ? $urandom : pick_value(),
               ($urandom_range(3) == 0) ? $urandom : pick_value());
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_edges();
    test_pool_full();
    test_random(1090);
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (!failed) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Watchdog: bounds a run of ~1250 command words with stalls, many times over.
  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/clst_pkg.sv
hw/rtl/clst_node_store.sv
hw/rtl/clst_free_stack.sv
hw/rtl/circular_list_engine_unit.sv
tb/circular_list_engine_unit_tb.sv
